### rtl/sha256_byte_stream_hasher_core_assert.svh
// Assertion macros used by the checker file.
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_ASSERT_SVH

// Clocked assertion, masked while reset is high.
`define SHABSH_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("shabsh assertion failed");

// Clocked assertion, also checked during reset.
`define SHABSH_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("shabsh assertion failed");

`endif

### rtl/shabsh_pkg.sv
// Types, constants and SHA-256 helper functions for the byte stream hasher.
package shabsh_pkg;

   typedef logic [7:0][31:0] words8_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       en;
      logic [5:0] pos;
      logic [7:0] value;
   } byte_wr_type;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam words8_type INIT_CHAIN = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

### rtl/shabsh_compress.sv
// Block word store, message schedule window and one-round-per-cycle SHA-256 unit.
module shabsh_compress import shabsh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  byte_wr_type wr,
   input  logic        start,
   input  words8_type  chain,
   output words8_type  work,
   output logic        busy,
   output logic        done
);

   logic [15:0][31:0] w_ff, w_in;
   words8_type        work_ff, work_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   logic [31:0] t1, t2, w_new, ch, maj;

   always_comb begin
      ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
            (work_ff[1] & work_ff[2]);
      t1 = work_ff[7] + big_sigma1(work_ff[4]) + ch + round_const(cnt_ff) + w_ff[0];
      t2 = big_sigma0(work_ff[0]) + maj;
      w_new = w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]);

      w_in    = w_ff;
      work_in = work_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;

      if (start) begin
         work_in = chain;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // window slides: word 0 is this round's schedule word
         w_in = {w_new, w_ff[15:1]};
         work_in = {work_ff[6:4], work_ff[3] + t1, work_ff[2:0], t1 + t2};
         cnt_in  = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
         end
      end

      if (wr.en && !busy_ff) begin
         w_in[wr.pos[5:2]][{~wr.pos[1:0], 3'b000} +: 8] = wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 6'd0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      work_ff <= work_in;
   end

   assign work = work_ff;
   assign busy = busy_ff;
   assign done = busy_ff && (cnt_ff == 6'd63);

endmodule

### rtl/sha256_byte_stream_hasher_core.sv
// SHA-256 byte stream hasher: top level, padding sequencer and digest output.
// A data item (tuser 0) appends one byte; the byte that fills a 64-byte
// block also starts the compression, which runs one round per cycle in a
// single shared round unit, so every 64th byte is followed by the 64 rounds
// and a fold of the result into the chaining words, and the block is not
// ready meanwhile. A finish item (tuser 1) writes the padding one byte a
// cycle through the same byte path (0x80, zeros, big-endian bit count),
// runs one compression, or two when more than 55 bytes were pending, then
// presents the eight digest words in order, one per accepted output item,
// word 7 with tlast. The next message starts after word 7 is taken. A finish
// takes longest with 56 bytes pending, and output stalls add to that.
module sha256_byte_stream_hasher_core import shabsh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] kind: 0 data, 1 finish
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
   output logic        rsp_tlast    // last_word
);

   state_type   state_ff, state_in;
   words8_type  chain_ff, chain_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        pad_ff, pad_in;      // finish in progress
   logic        first_ff, first_in;  // next pad byte is the 0x80 mark
   logic        lenok_ff, lenok_in;  // this block carries the bit count
   logic        final_ff, final_in;  // running compression is the last one
   logic [2:0]  idx_ff, idx_in;

   byte_wr_type wr;
   logic        start;
   logic        lenok_now;
   words8_type  work;
   logic        busy;
   logic        done;

   shabsh_compress u_compress (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .start (start),
      .chain (chain_ff),
      .work  (work),
      .busy  (busy),
      .done  (done)
   );

   always_comb begin
      state_in = state_ff;
      chain_in = chain_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      pad_in   = pad_ff;
      first_in = first_ff;
      lenok_in = lenok_ff;
      final_in = final_ff;
      idx_in   = idx_ff;
      wr       = '0;
      start    = 1'b0;
      lenok_now = lenok_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == KIND_DATA) begin
                  wr.en    = 1'b1;
                  wr.pos   = fill_ff;
                  wr.value = req_tdata;
                  fill_in  = fill_ff + 6'd1;
                  bits_in  = bits_ff + 64'd8;
                  if (fill_ff == 6'd63) begin
                     start    = 1'b1;
                     final_in = 1'b0;
                     state_in = ST_ROUND;
                  end
               end else begin
                  pad_in   = 1'b1;
                  first_in = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            wr.en  = 1'b1;
            wr.pos = fill_ff;
            if (first_ff) begin
               wr.value  = PAD_MARK;
               lenok_now = (fill_ff < 6'd56);
            end else if (fill_ff[5:3] == 3'b111 && lenok_ff) begin
               wr.value = bits_ff[{~fill_ff[2:0], 3'b000} +: 8];
            end else begin
               wr.value = 8'h00;
            end
            first_in = 1'b0;
            lenok_in = lenok_now;
            fill_in  = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               start    = 1'b1;
               final_in = lenok_now;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (done) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int k = 0; k < 8; k++) begin
               chain_in[k] = chain_ff[k] + work[k];
            end
            if (final_ff) begin
               idx_in   = 3'd0;
               state_in = ST_OUT;
            end else if (pad_ff) begin
               // mark went into the tail of the last block: length block follows
               lenok_in = 1'b1;
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  chain_in = INIT_CHAIN;
                  fill_in  = 6'd0;
                  bits_in  = 64'd0;
                  pad_in   = 1'b0;
                  final_in = 1'b0;
                  lenok_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chain_ff <= INIT_CHAIN;
         fill_ff  <= 6'd0;
         bits_ff  <= 64'd0;
         pad_ff   <= 1'b0;
         first_ff <= 1'b0;
         lenok_ff <= 1'b0;
         final_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         pad_ff   <= pad_in;
         first_ff <= first_in;
         lenok_ff <= lenok_in;
         final_ff <= final_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_tdata = {5'b00000, idx_ff, chain_ff[idx_ff]};
   assign rsp_tlast = (idx_ff == 3'd7);

   // round unit status is only consulted through done; busy spans ST_ROUND
   logic unused_busy;
   assign unused_busy = busy;

endmodule

### rtl/shabsh_checker.sv
// Port-level checker for the hasher, bound to the top level.
`include "sha256_byte_stream_hasher_core_assert.svh"
module shabsh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic unused_in;
   assign unused_in = req_tvalid ^ (^req_tdata) ^ req_tuser;

   `SHABSH_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `SHABSH_ASSERT_ALWAYS(a_no_in_during_out, rsp_tvalid |-> !req_tready)
   `SHABSH_ASSERT(a_last_is_seven, rsp_tvalid && rsp_tlast |-> rsp_tdata[34:32] == 3'd7)
   `SHABSH_ASSERT(a_index_steps, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1)

endmodule

bind sha256_byte_stream_hasher_core shabsh_checker u_shabsh_checker (.*);

### tb/sv/tb_top.sv
// Self-checking bench for the SHA-256 byte stream hasher: predicted digests vs. output items.
module tb_top;
   import shabsh_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tuser;   // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] digest_word, [34:32] word_index, rest 0
   logic        rsp_tlast;   // last_word

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } byte_item_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   sha256_byte_stream_hasher_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   byte_item_type   pending_bytes[$];
   digest_item_type expected_words[$];
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   bit           stim_done = 0;
   bit           calm_phase = 0;
   bit           long_hold = 0;

   // hash state kept by the predictor
   logic [31:0] hash_chain[8];
   logic [7:0]  msg_block[64];
   int unsigned msg_fill;
   logic [63:0] msg_bit_count;

   localparam logic [31:0] SHA_K[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) hash_chain[i] = INIT_CHAIN[i];
      msg_fill = 0;
      msg_bit_count = '0;
   endtask

   task automatic compress_block();
      logic [31:0] w[64];
      logic [31:0] r[8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) r[i] = hash_chain[i];
      for (int i = 0; i < 64; i++) begin
         t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
            + ((r[4] & r[5]) ^ (~r[4] & r[6])) + SHA_K[i] + w[i];
         t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
            + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
         r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
         r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_chain[i] += r[i];
   endtask

   // Advance the predictor by one accepted item; finish pushes 8 digest words.
   task automatic predict_digest(input byte_item_type it);
      int unsigned pos;
      digest_item_type d;
      if (it.kind == KIND_DATA) begin
         msg_block[msg_fill] = it.data_byte;
         msg_fill++;
         msg_bit_count += 64'd8;
         if (msg_fill == 64) begin
            compress_block();
            msg_fill = 0;
         end
      end else begin
         pos = msg_fill;
         msg_block[pos] = PAD_MARK;
         pos++;
         // more than 55 pending: length does not fit, spill into a second block
         if (pos > 56) begin
            while (pos < 64) begin msg_block[pos] = 8'h00; pos++; end
            compress_block();
            pos = 0;
         end
         while (pos < 56) begin msg_block[pos] = 8'h00; pos++; end
         for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bit_count[(7-i)*8 +: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            d.word = hash_chain[i];
            d.index = i[2:0];
            d.last = (i == 7);
            expected_words.push_back(d);
         end
         restart_hash();
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic queue_message(input int nbytes, input bit random_data, input logic [7:0] fill);
      byte_item_type it;
      for (int i = 0; i < nbytes; i++) begin
         it.kind = KIND_DATA;
         it.data_byte = random_data ? 8'($urandom) : fill;
         pending_bytes.push_back(it);
      end
      it.kind = KIND_FINISH;
      it.data_byte = 8'($urandom);   // ignored on finish
      pending_bytes.push_back(it);
   endtask

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // driver: stalls in random bursts, none during the calm phase
   int unsigned send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_digest('{req_tuser, req_tdata});
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               byte_item_type it;
               it = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= it.kind;
               req_tdata <= it.data_byte;
               if (!calm_phase && $urandom_range(0, 9) == 0)
                  send_gap <= $urandom_range(1, 19);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall control
   int unsigned rsp_gap = 0;
   int unsigned hold_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            digest_item_type e;
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_tdata));
            end else begin
               e = expected_words.pop_front();
               if (rsp_tdata[31:0] !== e.word)
                  report_mismatch($sformatf("word %h exp %h", rsp_tdata[31:0], e.word));
               if (rsp_tdata[34:32] !== e.index)
                  report_mismatch($sformatf("index %0d exp %0d", rsp_tdata[34:32], e.index));
               if (rsp_tlast !== e.last)
                  report_mismatch($sformatf("last %b exp %b", rsp_tlast, e.last));
               if (rsp_tdata[39:35] !== 5'b0)
                  report_mismatch("nonzero pad bits in output item");
            end
         end
         if (long_hold && hold_count < 3000) begin
            hold_count <= hold_count + 1;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm_phase && $urandom_range(0, 7) == 0)
               rsp_gap <= $urandom_range(1, 19);
         end
      end
   end

   initial begin
      int n;
      reset = 1'b1;
      rsp_tready = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      restart_hash();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty message, field extremes, spill into a length block,
      // a block filled by data alone
      queue_message(0, 0, 8'h00);
      queue_message(3, 0, 8'hff);
      queue_message(56, 1, 8'h00);
      queue_message(64, 1, 8'h00);
      // back-to-back finishes while the receiver is held off
      long_hold = 1;
      for (int i = 0; i < 4; i++) queue_message(i, 1, 8'h00);
      wait (pending_bytes.size() == 0 && expected_words.size() == 0);
      long_hold = 0;

      // a few short random messages
      for (int m = 0; m < 4; m++) begin
         n = $urandom_range(0, 4);
         if (m >= 2) calm_phase = 1;
         queue_message(n, 1, 8'h00);
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done && pending_bytes.size() == 0 && !req_tvalid
            && expected_words.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      wait (cycle_count >= 400000);
      $display("end of test: mismatches");
      $finish;
   end
endmodule

### sha256_byte_stream_hasher_core.f
+incdir+rtl
rtl/shabsh_pkg.sv
rtl/shabsh_compress.sv
rtl/sha256_byte_stream_hasher_core.sv
rtl/shabsh_checker.sv
tb/sv/tb_top.sv
